// ===== sv/assert_macros.svh =====
// Assertion macros used by the sorted list controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SLI_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define SLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sli_pkg.sv =====
// Package with codes, widths and shared types for the sorted list.
`timescale 1ns / 1ps
`default_nettype none
package sli_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] OP_READ   = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                       ins;
        logic                       del;
        logic signed [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]         index;
    } cell_ctl_t;

    // Summary gathered from the row of cells.
    typedef struct packed {
        logic                       found;
        logic signed [VALUE_W-1:0]  rd_value;
    } row_sum_t;

endpackage
`default_nettype wire

// ===== sv/sli_cell.sv =====
// One cell of the sorted row: holds a single entry and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none
module sli_cell #(
    parameter int CELL = 0,
    parameter int CW   = 7
) (
    input  wire logic                                 aclk,
    input  wire sli_pkg::cell_ctl_t                   ctl,
    input  wire logic [CW-1:0]                        count,
    input  wire logic                                 left_claim,
    input  wire logic                                 left_lt,
    input  wire logic signed [sli_pkg::VALUE_W-1:0]   left_data,
    input  wire logic signed [sli_pkg::VALUE_W-1:0]   right_data,
    output logic signed [sli_pkg::VALUE_W-1:0]        data,
    output logic                                      claim,
    output logic                                      lt,
    output logic                                      match,
    output logic signed [sli_pkg::VALUE_W-1:0]        rd_word
);

    localparam int MW = CW + sli_pkg::INDEX_W;

    logic signed [sli_pkg::VALUE_W-1:0] data_reg;
    logic signed [sli_pkg::VALUE_W-1:0] data_next;
    logic                               valid;

    // The entry is live when its position lies below the count.
    assign valid = (CW'(CELL) < count);

    // Insert position is the first cell that is empty or holds a greater value.
    assign claim = !valid || (ctl.value < data_reg);
    assign lt    = valid && (data_reg < ctl.value);
    // First equal entry: its left neighbour is smaller, or it is the head.
    assign match = valid && (data_reg == ctl.value) && left_lt;

    // Read word is zero unless this cell is the one addressed.
    assign rd_word = (valid && ({{CW{1'b0}}, ctl.index} == MW'(CELL))) ?
                     data_reg : '0;

    // Shift up on insert, shift down on delete from the removed entry onwards.
    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (left_claim) begin
                data_next = left_data;
            end else if (claim) begin
                data_next = ctl.value;
            end
        end else if (ctl.del && !lt) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// ===== sv/sli_ctrl.sv =====
// Request decode, entry count and result register of the sorted list.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sli_ctrl #(
    parameter int DEPTH = sli_pkg::DEPTH_DEFAULT,
    parameter int CW    = 7
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [sli_pkg::FUNC_W-1:0]           func,
    input  wire logic signed [sli_pkg::VALUE_W-1:0]   value,
    input  wire logic [sli_pkg::INDEX_W-1:0]          index,
    input  wire sli_pkg::row_sum_t                    sum,
    output sli_pkg::cell_ctl_t                        ctl,
    output logic [CW-1:0]                             count,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [sli_pkg::VALUE_W-1:0]        out_read_value,
    output logic [sli_pkg::COUNT_W-1:0]               out_entry_count,
    output logic [sli_pkg::STAT_W-1:0]                out_status
);

    logic                                 accept;
    logic                                 full;
    logic                                 idx_ok;
    logic                                 ins;
    logic                                 del;
    logic [CW-1:0]                        count_reg;
    logic [CW-1:0]                        count_next;
    logic [CW+sli_pkg::COUNT_W-1:0]       count_wide;
    logic [sli_pkg::STAT_W-1:0]           status_next;
    logic signed [sli_pkg::VALUE_W-1:0]   rd_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic signed [sli_pkg::VALUE_W-1:0]   rd_reg;
    logic [sli_pkg::COUNT_W-1:0]          ecount_reg;
    logic [sli_pkg::STAT_W-1:0]           status_reg;

    // A new word enters when the result register is free or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign full   = (count_reg == CW'(DEPTH));
    assign idx_ok = ({{CW{1'b0}}, index} < {{sli_pkg::INDEX_W{1'b0}}, count_reg});

    // Decode the request into a status and the cell strobes.
    always_comb begin
        status_next = sli_pkg::ST_OK;
        rd_next     = '0;
        ins         = 1'b0;
        del         = 1'b0;
        case (func)
            sli_pkg::OP_INSERT: begin
                if (full) begin
                    status_next = sli_pkg::ST_FULL;
                end else begin
                    ins = accept;
                end
            end
            sli_pkg::OP_DELETE: begin
                if (sum.found) begin
                    del = accept;
                end else begin
                    status_next = sli_pkg::ST_NOT_FOUND;
                end
            end
            sli_pkg::OP_READ: begin
                if (idx_ok) begin
                    rd_next = sum.rd_value;
                end else begin
                    status_next = sli_pkg::ST_RANGE;
                end
            end
            default: begin
                status_next = sli_pkg::ST_OK;
            end
        endcase
    end

    // Count follows the accepted insert or delete.
    always_comb begin
        count_next = count_reg;
        if (ins) begin
            count_next = count_reg + 1'b1;
        end else if (del) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign count_wide = {{sli_pkg::COUNT_W{1'b0}}, count_next};

    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload is loaded with each accepted word.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg     <= rd_next;
            ecount_reg <= count_wide[sli_pkg::COUNT_W-1:0];
            status_reg <= status_next;
        end
    end

    assign ctl.ins   = ins;
    assign ctl.del   = del;
    assign ctl.value = value;
    assign ctl.index = index;

    assign count           = count_reg;
    assign out_valid       = out_valid_reg;
    assign out_read_value  = rd_reg;
    assign out_entry_count = ecount_reg;
    assign out_status      = status_reg;

    `SLI_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CW'(DEPTH), "count above depth")
    `SLI_ASSERT_NEXT(a_ins_grows, aclk, aresetn, ins, count_reg == CW'($past(count_reg) + 1'b1), "insert did not grow the count")
    `SLI_ASSERT_NEXT(a_full_status, aclk, aresetn, accept && func == sli_pkg::OP_INSERT && status_next == sli_pkg::ST_FULL, count_reg == CW'(DEPTH) && status_reg == sli_pkg::ST_FULL, "full refusal with room left")

endmodule
`default_nettype wire

// ===== sv/sorted_list_insert_delete.sv =====
// Top level of the sorted list: a row of entry cells under one controller.
//
//  Port group | Dir | Handshake          | Content
//  s_         | in  | s_tvalid/s_tready  | request word: func, value, index
//  m_         | out | m_tvalid/m_tready  | result word: read_value, entry_count, status
//
// Every request is handled in the cycle it is accepted: all cells compare against
// the broadcast value at once and shift in the same clock edge, so one word per
// cycle is taken while the result register drains.
// A result appears in the cycle after its request is accepted and waits in the result register;
// s_tready drops only while that register is full and m_tready is low.
// Reset (aresetn low, synchronous) empties the list and the result register; the
// entry cells themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sorted_list_insert_delete #(
    parameter int DEPTH = sli_pkg::DEPTH_DEFAULT
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // [1:0] func, [33:2] value, [39:34] index
    input  wire logic [39:0]   s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [31:0] read_value, [38:32] entry_count, [40:39] status, [47:41] zero
    output logic [47:0]        m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = sli_pkg::VALUE_W;

    logic [sli_pkg::FUNC_W-1:0]    func;
    logic signed [VW-1:0]          value;
    logic [sli_pkg::INDEX_W-1:0]   index;
    sli_pkg::cell_ctl_t            ctl;
    sli_pkg::row_sum_t             sum;
    logic [CW-1:0]                 count;
    logic signed [VW-1:0]          out_read_value;
    logic [sli_pkg::COUNT_W-1:0]   out_entry_count;
    logic [sli_pkg::STAT_W-1:0]    out_status;

    logic signed [VW-1:0]          cell_data [DEPTH];
    logic signed [VW-1:0]          cell_rd   [DEPTH];
    logic [DEPTH-1:0]              cell_claim;
    logic [DEPTH-1:0]              cell_lt;
    logic [DEPTH-1:0]              cell_match;
    logic [DEPTH-1:0]              rd_col    [VW];

    // Unpack the request word.
    assign func  = s_tdata[1:0];
    assign value = s_tdata[33:2];
    assign index = s_tdata[39:34];

    // Row of cells, each wired to its left and right neighbour.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                  l_claim;
        logic                  l_lt;
        logic signed [VW-1:0]  l_data;
        logic signed [VW-1:0]  r_data;

        if (i == 0) begin : g_head
            assign l_claim = 1'b0;
            assign l_lt    = 1'b1;
            assign l_data  = '0;
        end else begin : g_body
            assign l_claim = cell_claim[i-1];
            assign l_lt    = cell_lt[i-1];
            assign l_data  = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign r_data = cell_data[i];
        end else begin : g_inner
            assign r_data = cell_data[i+1];
        end

        sli_cell #(
            .CELL (i),
            .CW   (CW)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .count      (count),
            .left_claim (l_claim),
            .left_lt    (l_lt),
            .left_data  (l_data),
            .right_data (r_data),
            .data       (cell_data[i]),
            .claim      (cell_claim[i]),
            .lt         (cell_lt[i]),
            .match      (cell_match[i]),
            .rd_word    (cell_rd[i])
        );

        for (genvar b = 0; b < VW; b++) begin : g_col
            assign rd_col[b][i] = cell_rd[i][b];
        end
    end

    // Only the addressed cell drives a non-zero read word, so an OR collects it.
    for (genvar b = 0; b < VW; b++) begin : g_rd
        assign sum.rd_value[b] = |rd_col[b];
    end
    assign sum.found = |cell_match;

    sli_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .func            (func),
        .value           (value),
        .index           (index),
        .sum             (sum),
        .ctl             (ctl),
        .count           (count),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_read_value  (out_read_value),
        .out_entry_count (out_entry_count),
        .out_status      (out_status)
    );

    // Pack the result word.
    assign m_tdata = {7'b0, out_status, out_entry_count, out_read_value};

endmodule
`default_nettype wire

// ===== test/sorted_list_insert_delete_tb.sv =====
// Self-checking testbench for the sorted list: directed and random requests against a mirror of the list.
`timescale 1ns / 1ps

module sorted_list_insert_delete_tb;

    localparam int LIST_DEPTH = sli_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_WORDS = 750;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_TAIL = 16;
    localparam int HOLD_CYCLES = 300;
    localparam logic [sli_pkg::FUNC_W-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [sli_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [sli_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // Request word, last field in the lowest bits.
    typedef struct packed {
        logic [sli_pkg::INDEX_W-1:0]        index;
        logic signed [sli_pkg::VALUE_W-1:0] value;
        logic [sli_pkg::FUNC_W-1:0]         func;
    } list_req_t;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [6:0]                         spare;
        logic [sli_pkg::STAT_W-1:0]         st;
        logic [sli_pkg::COUNT_W-1:0]        cnt;
        logic signed [sli_pkg::VALUE_W-1:0] rd;
    } list_result_t;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // Words waiting to be offered, and results the mirror says are due.
    list_req_t    request_q[$];
    list_result_t reply_q[$];

    // Values believed stored once every queued request has gone through.
    logic signed [sli_pkg::VALUE_W-1:0] stocked_q[$];

    // Mirror of the list, updated as each request word is accepted.
    logic signed [sli_pkg::VALUE_W-1:0] mirror_entries[LIST_DEPTH];
    int mirror_count = 0;

    int  queued_total = 0;
    int  accepted_cnt = 0;
    int  fail_count = 0;
    int  idle_cycles = 0;
    logic req_fired = 1'b0;

    int   send_gap = 0;
    int   send_mode_left = 0;
    logic send_busy = 1'b0;
    int   take_gap = 0;
    int   take_mode_left = 0;
    logic take_busy = 1'b0;
    int   hold_left = 0;
    int   holds_done = 0;

    sorted_list_insert_delete u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Applies one request to the mirror and returns the result it should produce.
    function automatic list_result_t list_predict(input list_req_t req);
        list_result_t res;
        int   pos;
        int   i;
        logic hit;
        res = '0;
        hit = 1'b0;
        pos = 0;
        case (req.func)
            sli_pkg::OP_INSERT: begin
                if (mirror_count >= LIST_DEPTH) begin
                    res.st = sli_pkg::ST_FULL;
                end else begin
                    // Goes in front of the first strictly greater entry.
                    pos = mirror_count;
                    for (i = 0; i < mirror_count; i++) begin
                        if (!hit && req.value < mirror_entries[i]) begin
                            pos = i;
                            hit = 1'b1;
                        end
                    end
                    for (i = mirror_count; i > pos; i--)
                        mirror_entries[i] = mirror_entries[i-1];
                    mirror_entries[pos] = req.value;
                    mirror_count++;
                end
            end
            sli_pkg::OP_DELETE: begin
                for (i = 0; i < mirror_count; i++) begin
                    if (!hit && mirror_entries[i] == req.value) begin
                        pos = i;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    res.st = sli_pkg::ST_NOT_FOUND;
                end else begin
                    for (i = pos; i + 1 < mirror_count; i++)
                        mirror_entries[i] = mirror_entries[i+1];
                    mirror_count--;
                end
            end
            sli_pkg::OP_READ: begin
                if (req.index < mirror_count)
                    res.rd = mirror_entries[req.index];
                else
                    res.st = sli_pkg::ST_RANGE;
            end
            default: begin
            end
        endcase
        res.cnt = mirror_count[sli_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Random entry position from zero up to the given bound.
    function automatic logic [sli_pkg::INDEX_W-1:0] pick_index(input int hi);
        int r;
        r = $urandom_range(0, hi);
        return r[sli_pkg::INDEX_W-1:0];
    endfunction

    // Corner values, a narrow band that gives duplicates, stored values, or anything.
    function automatic logic signed [sli_pkg::VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 4))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 32'sd0;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end else if (sel < 4) begin
            return $urandom_range(0, 16) - 8;
        end else if (sel < 6 && stocked_q.size() > 0) begin
            return stocked_q[$urandom_range(0, stocked_q.size() - 1)];
        end
        return $urandom;
    endfunction

    // Queues one request word and tracks what the list will then hold.
    task automatic queue_req(input logic [sli_pkg::FUNC_W-1:0] f,
                             input logic signed [sli_pkg::VALUE_W-1:0] v,
                             input logic [sli_pkg::INDEX_W-1:0] idx);
        list_req_t r;
        int k;
        r.func = f;
        r.value = v;
        r.index = idx;
        request_q.push_back(r);
        queued_total++;
        if (f == sli_pkg::OP_INSERT && stocked_q.size() < LIST_DEPTH) begin
            stocked_q.push_back(v);
        end else if (f == sli_pkg::OP_DELETE) begin
            for (k = 0; k < stocked_q.size(); k++) begin
                if (stocked_q[k] == v) begin
                    stocked_q.delete(k);
                    break;
                end
            end
        end
    endtask

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", what);
    endtask

    // Request side: hold the word until it is taken, then pause or offer the next.
    always @(negedge aclk) begin : req_drive
        logic      keep;
        list_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            if (send_mode_left == 0) begin
                send_busy = ($urandom_range(0, 2) != 0);
                send_mode_left = $urandom_range(30, 200);
            end else begin
                send_mode_left--;
            end
            keep = s_tvalid && !req_fired;
            nxt = s_tdata;
            if (!keep) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_q.size() > 0) begin
                    nxt = request_q.pop_front();
                    keep = 1'b1;
                    send_gap = send_busy ? pick_gap() : 0;
                end
            end
            s_tvalid <= keep;
            s_tdata <= nxt;
        end
    end

    // Result side: random stalls, plus two long hold-offs that back the list up.
    always @(negedge aclk) begin : reply_drive
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (take_mode_left == 0) begin
                take_busy = ($urandom_range(0, 2) != 0);
                take_mode_left = $urandom_range(30, 200);
            end else begin
                take_mode_left--;
            end
            if (hold_left == 0 && holds_done < 2 &&
                accepted_cnt >= 150 + 450 * holds_done) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                take_gap = take_busy ? pick_gap() : 0;
            end
        end
    end

    // Check each result word against the oldest expectation, then predict new requests.
    always @(posedge aclk) begin : reply_check
        list_result_t got;
        list_result_t want;
        if (!aresetn) begin
            req_fired <= 1'b0;
        end else begin
            req_fired <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (reply_q.size() == 0) begin
                    note_failure($sformatf("unexpected result word %h", m_tdata));
                end else begin
                    want = reply_q.pop_front();
                    if (got.rd !== want.rd || got.cnt !== want.cnt || got.st !== want.st ||
                        got.spare !== want.spare)
                        note_failure($sformatf(
                            {"mismatch: expected rd=%0d cnt=%0d st=%0d, ",
                             "got rd=%0d cnt=%0d st=%0d spare=%h"},
                            want.rd, want.cnt, want.st, got.rd, got.cnt, got.st, got.spare));
                end
            end
            if (s_tvalid && s_tready) begin
                reply_q.push_back(list_predict(list_req_t'(s_tdata)));
                accepted_cnt++;
            end
        end
    end

    // Watchdog: give up when nothing moves on either side for too long.
    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        op_mix_t mix;
        int counted;
        int span;
        int n;
        int r;
        int ins_w;
        int del_w;
        logic first_mix;

        // Directed part: empty list, both ends, duplicates, misses and the unused code.
        queue_req(sli_pkg::OP_READ, 32'sd0, 6'd0);
        queue_req(sli_pkg::OP_DELETE, 32'sd0, 6'd0);
        queue_req(sli_pkg::OP_INSERT, 32'sd0, 6'd0);
        queue_req(sli_pkg::OP_INSERT, VAL_MAX, 6'd0);
        queue_req(sli_pkg::OP_INSERT, VAL_MIN, 6'd0);
        queue_req(sli_pkg::OP_INSERT, 32'sd5, 6'd0);
        queue_req(sli_pkg::OP_INSERT, 32'sd5, 6'd0);
        queue_req(sli_pkg::OP_INSERT, -32'sd1, 6'd0);
        queue_req(sli_pkg::OP_READ, 32'sd0, 6'd0);
        queue_req(sli_pkg::OP_READ, 32'sd0, 6'd5);
        queue_req(sli_pkg::OP_READ, 32'sd0, 6'd6);
        queue_req(sli_pkg::OP_READ, 32'sd0, 6'd63);
        queue_req(sli_pkg::OP_DELETE, 32'sd7, 6'd0);
        queue_req(sli_pkg::OP_DELETE, 32'sd5, 6'd0);
        queue_req(sli_pkg::OP_DELETE, VAL_MIN, 6'd0);
        queue_req(sli_pkg::OP_DELETE, VAL_MAX, 6'd0);
        queue_req(OP_UNUSED, -32'sd1, 6'd63);
        queue_req(sli_pkg::OP_INSERT, 32'sh5555_5555, 6'd0);
        queue_req(sli_pkg::OP_INSERT, 32'shAAAA_AAAA, 6'd0);
        queue_req(sli_pkg::OP_READ, 32'sd0, 6'd1);
        queue_req(sli_pkg::OP_READ, 32'sd0, 6'd4);

        // Random part in spans that lean towards filling, draining or neither.
        counted = 0;
        first_mix = 1'b1;
        while (counted < RANDOM_WORDS) begin
            mix = first_mix ? MIX_FILL : op_mix_t'($urandom_range(0, 2));
            span = first_mix ? 120 : $urandom_range(40, 150);
            first_mix = 1'b0;
            case (mix)
                MIX_FILL: begin
                    ins_w = 77;
                    del_w = 5;
                end
                MIX_DRAIN: begin
                    ins_w = 10;
                    del_w = 70;
                end
                default: begin
                    ins_w = 35;
                    del_w = 30;
                end
            endcase
            for (n = 0; n < span && counted < RANDOM_WORDS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    queue_req(OP_UNUSED, $urandom, pick_index(63));
                end else if (r < 3 + ins_w) begin
                    queue_req(sli_pkg::OP_INSERT, pick_value(), pick_index(63));
                end else if (r < 3 + ins_w + del_w) begin
                    if (stocked_q.size() > 0 && $urandom_range(0, 4) != 0)
                        queue_req(sli_pkg::OP_DELETE,
                                  stocked_q[$urandom_range(0, stocked_q.size() - 1)],
                                  pick_index(63));
                    else
                        queue_req(sli_pkg::OP_DELETE, pick_value(), pick_index(63));
                end else begin
                    if (stocked_q.size() > 0 && $urandom_range(0, 6) != 0)
                        queue_req(sli_pkg::OP_READ, $urandom,
                                  pick_index(stocked_q.size() - 1));
                    else
                        queue_req(sli_pkg::OP_READ, $urandom, pick_index(63));
                end
                counted++;
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every word to be taken and every result to come back.
        while (accepted_cnt < queued_total)
            @(negedge aclk);
        while (reply_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_TAIL) @(negedge aclk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
